>>> hdl/pidz_pkg.sv
// ----------------------------------------------------------------------------
// PID integral zone controller package
// Payload, configuration and pipeline types shared by the controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pidz_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_ZONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd5;

    localparam logic [15:0] GAIN_P_RESET       = 16'd256;
    localparam logic [14:0] OUTPUT_LIMIT_RESET = 15'd127;

    typedef struct packed {
        logic signed [23:0] setpoint;
        logic signed [23:0] measured;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [22:0] integral_zone;
        logic [22:0] integral_limit;
        logic [14:0] output_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [24:0] err;
        logic signed [24:0] integ;
        logic signed [25:0] deriv;
    } t_terms;

    typedef struct packed {
        logic signed [44:0] prod_p;
        logic signed [44:0] prod_i;
        logic signed [44:0] prod_d;
    } t_prods;

endpackage

`default_nettype wire

>>> hdl/pid_integral_zone_controller_core.sv
// ----------------------------------------------------------------------------
// PID integral zone controller core
// PID controller with integral zone, integral clamp and saturated drive.
//
// Input channel i_in_valid/o_in_ready carries a setpoint and a measured
// position; output channel o_out_valid/i_out_ready returns one drive and a
// saturation flag per input transfer, in order. Gains and limits are set
// through the write port (i_cfg_wr_en, i_cfg_index, i_cfg_wdata); the user
// must write them only while idle, which the block does not enforce. The
// pipeline is four registers deep: input, terms, products, result. One
// transfer per cycle is taken in each direction unless a result is stalled;
// the three gain multipliers share one stage. The whole pipeline advances
// together: while a result waits on i_out_ready low, o_in_ready is low and
// all stages hold. Reset clears the stage valid flags, the stored error and
// integral, and loads the default register values (unity proportional gain,
// output limit 127); o_in_ready is low while reset is held.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_integral_zone_controller_core (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire  pidz_pkg::t_in_item              i_in_item,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output pidz_pkg::t_out_item                   o_out_item,
    input  wire                                   i_cfg_wr_en,
    input  wire  [pidz_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [pidz_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import pidz_pkg::*;

    t_cfg     r_cfg;
    t_in_item r_in_item;
    logic     r_in_valid;
    logic     r_terms_valid;
    logic     r_prods_valid;
    logic     r_out_valid;
    logic     w_adv;
    t_terms   w_terms;
    t_prods   w_prods;

    assign w_adv = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= GAIN_P_RESET;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.integral_zone  <= '0;
            r_cfg.integral_limit <= '0;
            r_cfg.output_limit   <= OUTPUT_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_GAIN_P:         r_cfg.gain_p         <= i_cfg_wdata[15:0];
                CFG_GAIN_I:         r_cfg.gain_i         <= i_cfg_wdata[15:0];
                CFG_GAIN_D:         r_cfg.gain_d         <= i_cfg_wdata[15:0];
                CFG_INTEGRAL_ZONE:  r_cfg.integral_zone  <= i_cfg_wdata[22:0];
                CFG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_wdata[22:0];
                CFG_OUTPUT_LIMIT:   r_cfg.output_limit   <= i_cfg_wdata[14:0];
                default: begin
                end
            endcase
        end
    end

    // advance all stage flags together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_terms_valid <= 1'b0;
            r_prods_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (w_adv) begin
            r_in_valid    <= i_in_valid;
            r_terms_valid <= r_in_valid;
            r_prods_valid <= r_terms_valid;
            r_out_valid   <= r_prods_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_item <= i_in_item;
        end
    end

    pidz_term_stage u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_in_valid),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_terms (w_terms)
    );

    pidz_product_stage u_product (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_terms (w_terms),
        .i_cfg   (r_cfg),
        .o_prods (w_prods)
    );

    pidz_drive_stage u_drive (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_prods (w_prods),
        .i_cfg   (r_cfg),
        .o_item  (o_out_item)
    );

    assign o_in_ready  = w_adv && i_rst_n;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> hdl/pidz_term_stage.sv
// ----------------------------------------------------------------------------
// PID term stage
// Forms the error, the zoned and clamped integral and the derivative, and
// holds the controller state.
// ----------------------------------------------------------------------------
`default_nettype none

module pidz_term_stage (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_adv,
    input  wire                     i_valid,
    input  wire pidz_pkg::t_in_item i_item,
    input  wire pidz_pkg::t_cfg     i_cfg,
    output pidz_pkg::t_terms        o_terms
);
    import pidz_pkg::*;

    logic signed [24:0] r_last_error;
    logic signed [24:0] r_integral;
    logic signed [24:0] n_integral;
    t_terms             r_terms;

    logic signed [24:0] w_err;
    logic        [24:0] w_mag;
    logic               w_in_zone;
    logic signed [25:0] w_sum;
    logic signed [25:0] w_lim;
    logic signed [25:0] w_neg_lim;
    logic signed [25:0] w_deriv;

    assign w_err     = $signed({i_item.setpoint[23], i_item.setpoint})
                     - $signed({i_item.measured[23], i_item.measured});
    assign w_mag     = w_err[24] ? 25'(-w_err) : 25'(w_err);
    assign w_in_zone = w_mag < {2'b00, i_cfg.integral_zone};
    assign w_sum     = $signed({r_integral[24], r_integral}) + $signed({w_err[24], w_err});
    assign w_lim     = $signed({3'b000, i_cfg.integral_limit});
    assign w_neg_lim = -w_lim;
    assign w_deriv   = $signed({w_err[24], w_err}) - $signed({r_last_error[24], r_last_error});

    always_comb begin
        if (!w_in_zone) begin
            n_integral = '0;
        end else if (w_sum > w_lim) begin
            n_integral = w_lim[24:0];
        end else if (w_sum < w_neg_lim) begin
            n_integral = w_neg_lim[24:0];
        end else begin
            n_integral = w_sum[24:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_integral   <= '0;
        end else if (i_adv && i_valid) begin
            r_last_error <= w_err;
            r_integral   <= n_integral;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_terms.err   <= w_err;
            r_terms.integ <= n_integral;
            r_terms.deriv <= w_deriv;
        end
    end

    assign o_terms = r_terms;

endmodule

`default_nettype wire

>>> hdl/pidz_product_stage.sv
// ----------------------------------------------------------------------------
// PID product stage
// Weights error, integral and derivative by their Q8.8 gains.
// ----------------------------------------------------------------------------
`default_nettype none

module pidz_product_stage (
    input  wire                   i_clk,
    input  wire                   i_adv,
    input  wire pidz_pkg::t_terms i_terms,
    input  wire pidz_pkg::t_cfg   i_cfg,
    output pidz_pkg::t_prods      o_prods
);
    import pidz_pkg::*;

    logic signed [44:0] w_prod_p;
    logic signed [44:0] w_prod_i;
    logic signed [44:0] w_prod_d;
    t_prods             r_prods;

    assign w_prod_p = $signed({1'b0, i_cfg.gain_p}) * i_terms.err;
    assign w_prod_i = $signed({1'b0, i_cfg.gain_i}) * i_terms.integ;
    assign w_prod_d = $signed({1'b0, i_cfg.gain_d}) * i_terms.deriv;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prods.prod_p <= w_prod_p;
            r_prods.prod_i <= w_prod_i;
            r_prods.prod_d <= w_prod_d;
        end
    end

    assign o_prods = r_prods;

endmodule

`default_nettype wire

>>> hdl/pidz_drive_stage.sv
// ----------------------------------------------------------------------------
// PID drive stage
// Sums the weighted terms, floors away the fraction and saturates the drive.
// ----------------------------------------------------------------------------
`default_nettype none

module pidz_drive_stage (
    input  wire                   i_clk,
    input  wire                   i_adv,
    input  wire pidz_pkg::t_prods i_prods,
    input  wire pidz_pkg::t_cfg   i_cfg,
    output pidz_pkg::t_out_item   o_item
);
    import pidz_pkg::*;

    logic signed [44:0] w_acc;
    logic signed [36:0] w_val;
    logic signed [36:0] w_lim;
    logic signed [36:0] w_neg_lim;
    t_out_item          n_item;
    t_out_item          r_item;

    assign w_acc     = i_prods.prod_p + i_prods.prod_i + i_prods.prod_d;
    assign w_val     = w_acc[44:8];
    assign w_lim     = $signed({22'd0, i_cfg.output_limit});
    assign w_neg_lim = -w_lim;

    always_comb begin
        if (w_val > w_lim) begin
            n_item.drive     = w_lim[15:0];
            n_item.saturated = 1'b1;
        end else if (w_val < w_neg_lim) begin
            n_item.drive     = w_neg_lim[15:0];
            n_item.saturated = 1'b1;
        end else begin
            n_item.drive     = w_val[15:0];
            n_item.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

>>> hdl/pidz_checker.sv
// ----------------------------------------------------------------------------
// PID integral zone controller checker
// Port-level properties of the controller core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pidz_checker (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    input  wire                      o_in_ready,
    input  wire                      o_out_valid,
    input  wire                      i_out_ready,
    input  wire pidz_pkg::t_out_item o_out_item
);
    import pidz_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output transfer dropped or changed while stalled");

    a_ready_only_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a waiting result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready ##1 o_in_ready ##1 o_in_ready ##1 o_in_ready
        |=> o_out_valid)
        else $error("result missing three cycles after input transfer");

endmodule

bind pid_integral_zone_controller_core pidz_checker u_pidz_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// PID integral zone controller testbench
// Drives setpoint/measured pairs through the controller under several gain
// and limit settings, with random gaps on both channels, and checks every
// drive and saturation flag against a cycle-free model of the controller.
// ----------------------------------------------------------------------------
module testbench;

    import pidz_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int N_ITEMS = 1750;
    localparam longint POS_MIN = -64'sd8388608;
    localparam longint POS_MAX = 64'sd8388607;

    class drive_scoreboard;
        t_cfg               cfg;
        logic signed [24:0] last_err;
        logic signed [24:0] integ_sum;
        t_out_item          drive_q[$];
        int                 errors;

        function new();
            cfg = '0;
            cfg.gain_p = GAIN_P_RESET;
            cfg.output_limit = OUTPUT_LIMIT_RESET;
            last_err = '0;
            integ_sum = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GAIN_P: cfg.gain_p = data[15:0];
                CFG_GAIN_I: cfg.gain_i = data[15:0];
                CFG_GAIN_D: cfg.gain_d = data[15:0];
                CFG_INTEGRAL_ZONE: cfg.integral_zone = data[22:0];
                CFG_INTEGRAL_LIMIT: cfg.integral_limit = data[22:0];
                CFG_OUTPUT_LIMIT: cfg.output_limit = data[14:0];
                default: ;
            endcase
        endfunction

        function void predict_drive(t_in_item item);
            longint    err;
            longint    mag;
            longint    integ;
            longint    deriv;
            longint    acc;
            longint    val;
            longint    lim;
            t_out_item res;
            err = longint'(item.setpoint) - longint'(item.measured);
            mag = (err < 0) ? -err : err;
            integ = integ_sum;
            if (mag < longint'(cfg.integral_zone)) begin
                integ = integ + err;
            end else begin
                integ = 0;
            end
            lim = cfg.integral_limit;
            if (integ > lim) begin
                integ = lim;
            end else if (integ < -lim) begin
                integ = -lim;
            end
            deriv = err - longint'(last_err);
            last_err = 25'(err);
            integ_sum = 25'(integ);
            acc = longint'(cfg.gain_p) * err + longint'(cfg.gain_i) * integ
                + longint'(cfg.gain_d) * deriv;
            val = acc >>> 8;
            lim = cfg.output_limit;
            res.drive = 16'(val);
            res.saturated = 1'b0;
            if (val > lim) begin
                res.drive = 16'(lim);
                res.saturated = 1'b1;
            end else if (val < -lim) begin
                res.drive = 16'(-lim);
                res.saturated = 1'b1;
            end
            drive_q.push_back(res);
        endfunction

        function void check_drive(t_out_item got);
            t_out_item want;
            if (drive_q.size() == 0) begin
                $error("unexpected result: drive %0d saturated %0d", got.drive, got.saturated);
                errors++;
                return;
            end
            want = drive_q.pop_front();
            if (got.drive !== want.drive) begin
                $error("drive: expected %0d, actual %0d", want.drive, got.drive);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
                errors++;
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_item = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_item;

    bit                    tx_idle = 1'b1;
    bit                    rx_idle = 1'b1;
    int                    n_sent = 0;
    int unsigned           cycle_count = 0;
    drive_scoreboard       sb;

    pid_integral_zone_controller_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_wr_en (cfg_we),
        .i_cfg_index (cfg_idx),
        .i_cfg_wdata (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            sb.check_drive(o_out_item);
        end
    end

    initial begin : receiver
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_idle ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_item(input t_in_item item);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.predict_drive(item);
        n_sent++;
    endtask

    task automatic send_pair(input longint sp, input longint ms);
        t_in_item item;
        item.setpoint = 24'(sp);
        item.measured = 24'(ms);
        send_item(item);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // upper bits beyond the register width carry noise and must be dropped
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [22:0] value,
                             input int width);
        logic [CFG_DATA_W-1:0] data;
        data = value | CFG_DATA_W'($urandom << width);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic load_settings(input t_cfg s);
        write_reg(CFG_GAIN_P, 23'(s.gain_p), 16);
        write_reg(CFG_GAIN_I, 23'(s.gain_i), 16);
        write_reg(CFG_GAIN_D, 23'(s.gain_d), 16);
        write_reg(CFG_INTEGRAL_ZONE, s.integral_zone, 23);
        write_reg(CFG_INTEGRAL_LIMIT, s.integral_limit, 23);
        write_reg(CFG_OUTPUT_LIMIT, 23'(s.output_limit), 15);
        if ($urandom_range(0, 1)) begin
            write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, 23'($urandom), 0);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [22:0] pick_value(int width);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 23'((1 << width) - 1);
            2: return 23'($urandom_range(0, 64));
            3: return 23'($urandom_range(0, 4096));
            default: return 23'($urandom & ((1 << width) - 1));
        endcase
    endfunction

    function automatic longint clamp_pos(longint v);
        if (v > POS_MAX) begin
            return POS_MAX;
        end
        if (v < POS_MIN) begin
            return POS_MIN;
        end
        return v;
    endfunction

    function automatic longint random_pos();
        return longint'($urandom_range(0, 24'hFFFFFF)) + POS_MIN;
    endfunction

    // mostly errors near or inside the zone, so the integral gets to build up
    task automatic send_random();
        longint ms;
        longint sp;
        longint span;
        ms = random_pos();
        case ($urandom_range(0, 9))
            0, 1: span = 16;
            2: span = 4096;
            3, 4, 5: span = longint'(sb.cfg.integral_zone) + 1;
            6, 7, 8: span = -1;
            default: span = -2;
        endcase
        if (span > 0) begin
            sp = clamp_pos(ms + longint'($urandom_range(0, 32'(2 * span))) - span);
        end else if (span == -1) begin
            sp = random_pos();
        end else begin
            sp = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
            ms = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        end
        send_pair(sp, ms);
    endtask

    initial begin : stimulus
        t_cfg s;
        int   count;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_pair(POS_MAX, POS_MIN);
        send_pair(POS_MIN, POS_MAX);
        send_pair(0, 0);
        send_pair(100, -27);
        send_pair(128, 0);
        send_pair(-127, 0);
        send_pair(-128, 0);
        send_pair(POS_MAX, POS_MAX);
        drain();

        load_settings('{16'hFFFF, 16'hFFFF, 16'hFFFF, 23'h7FFFFF, 23'h7FFFFF, 15'h7FFF});
        send_pair(POS_MAX, POS_MIN);
        send_pair(POS_MIN, POS_MAX);
        send_pair(4000000, 0);
        send_pair(4000000, 0);
        send_pair(4000000, 0);
        send_pair(-1, 0);
        drain();

        load_settings('{16'd0, 16'd256, 16'd0, 23'd1000, 23'd50, 15'd0});
        send_pair(30, 0);
        send_pair(30, 0);
        send_pair(-999, 0);
        send_pair(1000, 0);
        send_pair(0, 0);
        drain();

        load_settings('{16'd256, 16'd256, 16'd256, 23'd1000, 23'd50, 15'd127});
        send_pair(40, 0);
        send_pair(40, 0);
        send_pair(-40, 0);
        send_pair(0, 40);
        drain();

        while (n_sent < N_ITEMS) begin
            s.gain_p = 16'(pick_value(16));
            s.gain_i = 16'(pick_value(16));
            s.gain_d = 16'(pick_value(16));
            s.integral_zone = pick_value(23);
            s.integral_limit = pick_value(23);
            s.output_limit = 15'(pick_value(15));
            load_settings(s);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            count = $urandom_range(80, 200);
            repeat (count) begin
                send_random();
                if ($urandom_range(0, 99) == 0) begin
                    drain();
                end
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
